// ===== hw/rtl/cialu_pkg.sv =====
// ----------------------------------------------------------------------------
// cialu_pkg
// Shared types and constants for the complex integer arithmetic unit.
// ----------------------------------------------------------------------------
package cialu_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int RES_W         = 33;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;
endpackage

// ===== hw/rtl/cialu_div_cell.sv =====
// ----------------------------------------------------------------------------
// cialu_div_cell
// One restoring-division step for both quotients; hands data to the next cell.
// ----------------------------------------------------------------------------
module cialu_div_cell #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_v,
  input  logic          in_hold,
  input  logic [NW-1:0] in_rem_r,
  input  logic [NW-1:0] in_rem_i,
  input  logic [DW-1:0] in_den,
  input  logic [NW-1:0] in_q_r,
  input  logic [NW-1:0] in_q_i,
  input  logic [2:0]    in_tag,
  input  logic [cialu_pkg::RES_W-1:0] in_pr,
  input  logic [cialu_pkg::RES_W-1:0] in_pi,
  output logic          out_v,
  output logic [NW-1:0] out_rem_r,
  output logic [NW-1:0] out_rem_i,
  output logic [DW-1:0] out_den,
  output logic [NW-1:0] out_q_r,
  output logic [NW-1:0] out_q_i,
  output logic [2:0]    out_tag,
  output logic [cialu_pkg::RES_W-1:0] out_pr,
  output logic [cialu_pkg::RES_W-1:0] out_pi
);
  // compare remainder against den << BIT
  logic [NW+DW-1:0] sh;
  logic             ge_r, ge_i;
  assign sh   = {{NW{1'b0}}, in_den} << BIT;
  assign ge_r = {{DW{1'b0}}, in_rem_r} >= sh;
  assign ge_i = {{DW{1'b0}}, in_rem_i} >= sh;

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (!in_hold) out_v <= in_v;
    if (!in_hold) begin
      out_rem_r <= ge_r ? in_rem_r - sh[NW-1:0] : in_rem_r;
      out_rem_i <= ge_i ? in_rem_i - sh[NW-1:0] : in_rem_i;
      out_q_r   <= in_q_r | (NW'(ge_r) << BIT);
      out_q_i   <= in_q_i | (NW'(ge_i) << BIT);
      out_den   <= in_den;
      out_tag   <= in_tag;
      out_pr    <= in_pr;
      out_pi    <= in_pi;
    end
  end
endmodule

// ===== hw/rtl/complex_integer_alu_unit.sv =====
// ----------------------------------------------------------------------------
// complex_integer_alu_unit
// Complex add, subtract, multiply and truncating divide over a stream.
// ----------------------------------------------------------------------------
// Every opcode takes the same path (one pipeline for all): products, sums,
//   the division cells, then the output stage. Throughput: one word per cycle
//   while the output is not held; one quotient bit per cell, 2*OPERAND_WIDTH+1 cells.
// Whole chain stalls together when the output is held.
// Reset (rst, synchronous) clears the valid bits only; no clearing pass.
module complex_integer_alu_unit #(
  parameter int OPERAND_WIDTH = cialu_pkg::OPERAND_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  // opcode[1:0], a_real, a_imag, b_real, b_imag (OPERAND_WIDTH each), zero pad
  input  logic [((2+4*OPERAND_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic       m_tvalid,
  input  logic       m_tready,
  // result_real[32:0], result_imag[32:0], zero pad
  output logic [71:0] m_tdata,
  // divide_by_zero
  output logic       m_tuser
);
  localparam int W   = OPERAND_WIDTH;
  localparam int PW  = 2*W;
  localparam int NW  = 2*W+1;
  localparam int DW  = 2*W+1;
  localparam int NC  = NW;
  localparam int RW  = cialu_pkg::RES_W;

  logic hold;
  logic [W-1:0] ar, ai, br, bi;
  logic [1:0]   op;
  assign op = s_tdata[1:0];
  assign ar = s_tdata[2+W-1:2];
  assign ai = s_tdata[2+2*W-1:2+W];
  assign br = s_tdata[2+3*W-1:2+2*W];
  assign bi = s_tdata[2+4*W-1:2+3*W];

  // stage 1: products, operand sums and differences
  logic          v1;
  logic [1:0]    op1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [W:0]    s_r, s_i, d_r, d_i;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (!hold) v1 <= s_tvalid;
    if (!hold) begin
      op1  <= op;
      p_rr <= $signed(ar) * $signed(br);
      p_ii <= $signed(ai) * $signed(bi);
      p_ri <= $signed(ar) * $signed(bi);
      p_ir <= $signed(ai) * $signed(br);
      s_r  <= $signed({ar[W-1], ar}) + $signed({br[W-1], br});
      s_i  <= $signed({ai[W-1], ai}) + $signed({bi[W-1], bi});
      d_r  <= $signed({ar[W-1], ar}) - $signed({br[W-1], br});
      d_i  <= $signed({ai[W-1], ai}) - $signed({bi[W-1], bi});
    end
  end
  logic signed [PW-1:0] q_bb, q_ii2;
  always_ff @(posedge clk) begin
    if (!hold) begin
      q_bb  <= $signed(br) * $signed(br);
      q_ii2 <= $signed(bi) * $signed(bi);
    end
  end

  // stage 2: sums, signs, magnitudes, denominator and add/sub/mul results
  logic          v2;
  logic [2:0]    tag2; // {neg_r, neg_i, dz}
  logic [NW-1:0] mag_r, mag_i;
  logic [DW-1:0] den2;
  logic [RW-1:0] pr2, pi2;
  logic signed [NW:0] nr, ni, mr, mi;
  logic [DW-1:0] den_c;
  logic          isdiv;
  always_comb begin
    nr    = (NW+1)'(p_rr) + (NW+1)'(p_ii);
    ni    = (NW+1)'(p_ir) - (NW+1)'(p_ri);
    mr    = (NW+1)'(p_rr) - (NW+1)'(p_ii);
    mi    = (NW+1)'(p_ri) + (NW+1)'(p_ir);
    den_c = DW'($unsigned(q_bb)) + DW'($unsigned(q_ii2));
    isdiv = op1 == cialu_pkg::OP_DIV;
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (!hold) v2 <= v1;
    if (!hold) begin
      den2  <= (den_c == '0) ? DW'(1) : den_c;
      tag2  <= isdiv ? {nr[NW], ni[NW], den_c == '0} : 3'b000;
      mag_r <= nr[NW] ? NW'(-nr) : NW'(nr);
      mag_i <= ni[NW] ? NW'(-ni) : NW'(ni);
      case (op1)
        cialu_pkg::OP_ADD: begin pr2 <= RW'(s_r); pi2 <= RW'(s_i); end
        cialu_pkg::OP_SUB: begin pr2 <= RW'(d_r); pi2 <= RW'(d_i); end
        cialu_pkg::OP_MUL: begin pr2 <= RW'(mr);  pi2 <= RW'(mi);  end
        default:           begin pr2 <= '0;       pi2 <= '0;       end
      endcase
    end
  end
  logic isdiv2;
  always_ff @(posedge clk) if (!hold) isdiv2 <= isdiv;

  // division chain, most significant quotient bit first
  logic          cv [NC+1];
  logic [NW-1:0] crr [NC+1], cri [NC+1], cqr [NC+1], cqi [NC+1];
  logic [DW-1:0] cd [NC+1];
  logic [2:0]    ct [NC+1];
  logic [RW-1:0] cpr [NC+1], cpi [NC+1];
  logic          dv [NC+1];
  assign cv[0] = v2;  assign crr[0] = mag_r; assign cri[0] = mag_i;
  assign cqr[0] = '0; assign cqi[0] = '0;    assign cd[0] = den2;
  assign ct[0] = tag2; assign cpr[0] = pr2;  assign cpi[0] = pi2;
  assign dv[0] = isdiv2;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cialu_div_cell #(.NW(NW), .DW(DW), .BIT(NC-1-k)) u_cell (
      .clk, .rst, .in_v(cv[k]), .in_hold(hold),
      .in_rem_r(crr[k]), .in_rem_i(cri[k]), .in_den(cd[k]),
      .in_q_r(cqr[k]), .in_q_i(cqi[k]), .in_tag(ct[k]),
      .in_pr(cpr[k]), .in_pi(cpi[k]),
      .out_v(cv[k+1]), .out_rem_r(crr[k+1]), .out_rem_i(cri[k+1]),
      .out_den(cd[k+1]), .out_q_r(cqr[k+1]), .out_q_i(cqi[k+1]),
      .out_tag(ct[k+1]), .out_pr(cpr[k+1]), .out_pi(cpi[k+1])
    );
    always_ff @(posedge clk) if (!hold) dv[k+1] <= dv[k];
  end

  // output stage
  logic [RW-1:0] res_r, res_i, qr, qi;
  logic          dz;
  assign qr = ct[NC][2] ? RW'(-cqr[NC]) : RW'(cqr[NC]);
  assign qi = ct[NC][1] ? RW'(-cqi[NC]) : RW'(cqi[NC]);
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (!hold) m_tvalid <= cv[NC];
    if (!hold) begin
      dz    <= ct[NC][0];
      res_r <= dv[NC] ? (ct[NC][0] ? '0 : qr) : cpr[NC];
      res_i <= dv[NC] ? (ct[NC][0] ? '0 : qi) : cpi[NC];
    end
  end
  assign hold     = m_tvalid && !m_tready;
  assign s_tready = !hold;
  assign m_tdata  = {6'b0, res_i, res_r};
  assign m_tuser  = dz;

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> res_r == '0 && res_i == '0)
    else $error("divide by zero with nonzero parts");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(res_r))
    else $error("result lost under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");
endmodule
